// File: design/mkd_pkg.sv
// Package for the Morse key decoder: sizes, reset values, result types and
// the Morse code table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mkd_pkg;

  // Sizes
  localparam int MAX_MARKS   = 5;
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_W       = 16;
  localparam int CNT_W       = $clog2(MAX_MARKS + 1);
  localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam int CHAR_W      = 7;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // Register indexes and reset values
  localparam logic [0:0] REG_DOT_MAX    = 1'd0;
  localparam logic [0:0] REG_LETTER_GAP = 1'd1;
  localparam logic [CFG_W-1:0] DOT_MAX_RESET    = CFG_W'(250);
  localparam logic [CFG_W-1:0] LETTER_GAP_RESET = CFG_W'(1500);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

  // Code table: length in marks and mark pattern (first mark in bit 0, 1 = dash)
  localparam int TABLE_SIZE = 36;
  localparam int PAT_W      = 5;

  localparam logic [2:0] CODE_LEN [TABLE_SIZE] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4,
    3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4,
    3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5
  };

  localparam logic [PAT_W-1:0] CODE_PAT [TABLE_SIZE] = '{
    5'd2,  5'd1,  5'd5,  5'd1,  5'd0,  5'd4,  5'd3,  5'd0,  5'd0,  5'd14, 5'd5,  5'd2,
    5'd3,  5'd1,  5'd7,  5'd6,  5'd11, 5'd2,  5'd0,  5'd1,  5'd4,  5'd8,  5'd6,  5'd9,
    5'd13, 5'd3,  5'd30, 5'd28, 5'd24, 5'd16, 5'd0,  5'd1,  5'd3,  5'd7,  5'd15, 5'd31
  };

  localparam logic [CHAR_W-1:0] CODE_CHAR [TABLE_SIZE] = '{
    7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A, 7'h4B, 7'h4C,
    7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54, 7'h55, 7'h56, 7'h57, 7'h58,
    7'h59, 7'h5A, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
  };

  // Held marks handed to the decoder
  typedef struct packed {
    logic [CNT_W-1:0]     count;
    logic [MAX_MARKS-1:0] bits;
  } marks_t;

  // Decoder answer
  typedef struct packed {
    logic              miss;
    logic [CHAR_W-1:0] code;
  } decode_t;

  // One result item, last field in bit 0
  typedef struct packed {
    logic              unmatched;
    logic [CHAR_W-1:0] char_code;
    logic              char_valid;
    logic              mark_is_dash;
    logic              mark_valid;
  } result_t;

  localparam int RES_W = $bits(result_t);

endpackage

`default_nettype wire

// File: design/mkd_decode.sv
// Morse table lookup: held marks to ASCII, with a miss flag.
// Depends on mkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkd_decode (
  input  wire mkd_pkg::marks_t  marks,
  output mkd_pkg::decode_t      result
);

  logic [mkd_pkg::TABLE_SIZE-1:0] hit;
  logic [mkd_pkg::CHAR_W-1:0]     code_or;

  // every entry compared in parallel; at most one can hit
  always_comb begin
    for (int i = 0; i < mkd_pkg::TABLE_SIZE; i++) begin
      hit[i] = (marks.count == mkd_pkg::CNT_W'(mkd_pkg::CODE_LEN[i])) &&
               (marks.bits == mkd_pkg::MAX_MARKS'(mkd_pkg::CODE_PAT[i]));
    end
  end

  always_comb begin
    code_or = '0;
    for (int i = 0; i < mkd_pkg::TABLE_SIZE; i++) begin
      code_or = code_or | (hit[i] ? mkd_pkg::CODE_CHAR[i] : '0);
    end
  end

  assign result.miss = ~(|hit);
  assign result.code = (|hit) ? code_or : mkd_pkg::CHAR_SPACE;

endmodule

`default_nettype wire

// File: design/mkd_tracker.sv
// Key timing state: press and gap counters, held marks, and the per-tick result.
// Depends on mkd_pkg; takes its character from mkd_decode.
`timescale 1ns / 1ps
`default_nettype none

module mkd_tracker (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             accept,
  input  wire                             key_down,
  input  wire  [mkd_pkg::CFG_W-1:0]       dot_max_ticks,
  input  wire  [mkd_pkg::CFG_W-1:0]       letter_gap_ticks,
  input  wire  mkd_pkg::decode_t          dec,
  output mkd_pkg::marks_t                 marks,
  output mkd_pkg::result_t                result
);

  logic                               key_was_down, key_was_down_next;
  logic [mkd_pkg::COUNT_WIDTH-1:0]    press_ticks, press_ticks_next;
  logic [mkd_pkg::COUNT_WIDTH-1:0]    gap_ticks, gap_ticks_next;
  logic [mkd_pkg::CNT_W-1:0]          mark_count, mark_count_next;
  logic [mkd_pkg::MAX_MARKS-1:0]      mark_bits, mark_bits_next;

  logic [mkd_pkg::CNT_W-1:0]          cnt_upd;
  logic [mkd_pkg::MAX_MARKS-1:0]      bits_upd;
  logic [mkd_pkg::COUNT_WIDTH-1:0]    gap_sat;
  logic                               m_valid, m_dash, do_dec;

  always_comb begin
    key_was_down_next = key_down;
    press_ticks_next  = press_ticks;
    gap_ticks_next    = gap_ticks;
    cnt_upd           = mark_count;
    bits_upd          = mark_bits;
    m_valid           = 1'b0;
    m_dash            = 1'b0;
    do_dec            = 1'b0;
    gap_sat           = (gap_ticks == mkd_pkg::COUNT_MAX) ? gap_ticks
                        : gap_ticks + mkd_pkg::COUNT_WIDTH'(1);

    if (key_down) begin
      if (!key_was_down) begin
        press_ticks_next = mkd_pkg::COUNT_WIDTH'(1);
      end else if (press_ticks != mkd_pkg::COUNT_MAX) begin
        press_ticks_next = press_ticks + mkd_pkg::COUNT_WIDTH'(1);
      end
    end else if (key_was_down) begin
      // release: store the mark, restart the gap
      m_valid  = 1'b1;
      m_dash   = mkd_pkg::CMP_W'(press_ticks) > mkd_pkg::CMP_W'(dot_max_ticks);
      bits_upd[mark_count] = m_dash;
      cnt_upd  = mark_count + mkd_pkg::CNT_W'(1);
      gap_ticks_next = '0;
      do_dec   = (cnt_upd == mkd_pkg::CNT_W'(mkd_pkg::MAX_MARKS));
    end else begin
      gap_ticks_next = gap_sat;
      do_dec = (mark_count != '0) &&
               (mkd_pkg::CMP_W'(gap_sat) > mkd_pkg::CMP_W'(letter_gap_ticks));
    end

    mark_count_next = do_dec ? '0 : cnt_upd;
    mark_bits_next  = do_dec ? '0 : bits_upd;
  end

  assign marks.count = cnt_upd;
  assign marks.bits  = bits_upd;

  assign result.mark_valid   = m_valid;
  assign result.mark_is_dash = m_dash;
  assign result.char_valid   = do_dec;
  assign result.char_code    = do_dec ? dec.code : '0;
  assign result.unmatched    = do_dec & dec.miss;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_was_down <= 1'b0;
      press_ticks  <= '0;
      gap_ticks    <= '0;
      mark_count   <= '0;
      mark_bits    <= '0;
    end else if (accept) begin
      key_was_down <= key_was_down_next;
      press_ticks  <= press_ticks_next;
      gap_ticks    <= gap_ticks_next;
      mark_count   <= mark_count_next;
      mark_bits    <= mark_bits_next;
    end
  end

endmodule

`default_nettype wire

// File: design/mkd_out_buf.sv
// Two-entry result buffer: output register plus skid register.
// Depends on mkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mkd_out_buf (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       push,
  input  wire  mkd_pkg::result_t    push_data,
  output logic                      push_ready,
  output logic                      out_valid,
  input  wire                       out_ready,
  output mkd_pkg::result_t          out_data
);

  logic              main_valid, skid_valid;
  mkd_pkg::result_t  main_data, skid_data;
  logic              pop;

  assign pop        = main_valid & out_ready;
  assign push_ready = ~skid_valid;
  assign out_valid  = main_valid;
  assign out_data   = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (!main_valid) begin
      main_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (pop) begin
      main_data <= skid_valid ? skid_data : push_data;
    end else if (!main_valid) begin
      main_data <= push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: design/morse_key_decoder_core.sv
// Morse key decoder top level: one item per millisecond tick carries the key level.
// Each accepted item's result is registered; it queues behind an unsent earlier result.
// Throughput: one item per cycle, s_tready permitting; parallel 36-entry table decode.
// A two-entry output buffer keeps s_tready high while one result waits.
// Reset (rst, synchronous): counters and held marks cleared, registers to 250/1500.
`timescale 1ns / 1ps
`default_nettype none

module morse_key_decoder_core (
  input  wire                                clk,
  input  wire                                rst,
  // tick items in
  input  wire                                s_tvalid,
  output logic                               s_tready,
  input  wire  [mkd_pkg::IN_TDATA_W-1:0]     s_tdata,   // [0] key_down
  // result items out
  output logic                               m_tvalid,
  input  wire                                m_tready,
  output logic [mkd_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [0] mark_valid, [1] mark_is_dash,
                                                        // [2] char_valid, [9:3] char_code,
                                                        // [10] unmatched
  // configuration writes
  input  wire                                cfg_we,
  input  wire  [0:0]                         cfg_index,
  input  wire  [mkd_pkg::CFG_W-1:0]          cfg_data
);

  logic [mkd_pkg::CFG_W-1:0] dot_max_ticks;
  logic [mkd_pkg::CFG_W-1:0] letter_gap_ticks;

  logic              accept;
  mkd_pkg::marks_t   marks;
  mkd_pkg::decode_t  dec;
  mkd_pkg::result_t  step_res;
  mkd_pkg::result_t  out_res;

  // config registers; both indexes are in use so no write is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_max_ticks    <= mkd_pkg::DOT_MAX_RESET;
      letter_gap_ticks <= mkd_pkg::LETTER_GAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mkd_pkg::REG_DOT_MAX:    dot_max_ticks    <= cfg_data;
        mkd_pkg::REG_LETTER_GAP: letter_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid & s_tready;

  // timing state and mark capture; the state only moves on an accepted tick
  mkd_tracker u_tracker (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .key_down         (s_tdata[0]),
    .dot_max_ticks    (dot_max_ticks),
    .letter_gap_ticks (letter_gap_ticks),
    .dec              (dec),
    .marks            (marks),
    .result           (step_res)
  );

  // table lookup on the marks as they stand after this tick's release
  mkd_decode u_decode (
    .marks  (marks),
    .result (dec)
  );

  // result register with skid slot
  mkd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (step_res),
    .push_ready (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_res)
  );

  assign m_tdata = {{(mkd_pkg::OUT_TDATA_W - mkd_pkg::RES_W){1'b0}}, out_res};

  // Assertions

  // skid slot only fills behind a full output register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("skid full while output register empty");

  // a miss always reads as a space
  a_miss_is_space: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.unmatched) |-> (out_res.char_valid &&
                                         out_res.char_code == mkd_pkg::CHAR_SPACE))
    else $error("unmatched result without space character");

  // no character fields without a decode
  a_idle_char_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !out_res.char_valid) |-> (out_res.char_code == '0))
    else $error("char_code set without char_valid");

  // a dash is only reported with a mark
  a_dash_needs_mark: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.mark_is_dash) |-> out_res.mark_valid)
    else $error("mark_is_dash without mark_valid");

endmodule

`default_nettype wire

// File: sim/mkd_checker.sv
// Result checker for the Morse key decoder bench: tracks tick items and register writes,
// predicts each result item and compares it against the block's output channel.
// Depends on mkd_pkg for port widths and register indexes.
`timescale 1ns / 1ps

module mkd_checker (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  input  wire                             s_tready,
  input  wire [mkd_pkg::IN_TDATA_W-1:0]   s_tdata,   // [0] key_down
  input  wire                             m_tvalid,
  input  wire                             m_tready,
  input  wire [mkd_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [0] mark_valid, [1] mark_is_dash,
                                                     // [2] char_valid, [9:3] char_code,
                                                     // [10] unmatched
  input  wire                             cfg_we,
  input  wire [0:0]                       cfg_index,
  input  wire [mkd_pkg::CFG_W-1:0]        cfg_data,
  output int                              errors,
  output int                              pending
);

  localparam logic [15:0] DOT_LIMIT_INIT = 16'd250;
  localparam logic [15:0] GAP_LIMIT_INIT = 16'd1500;
  localparam int          MARKS_PER_CHAR = 5;

  typedef struct packed {
    logic       unmatched;
    logic [6:0] char_code;
    logic       char_valid;
    logic       mark_is_dash;
    logic       mark_valid;
  } tick_result_t;

  localparam int RESULT_W = $bits(tick_result_t);

  logic [15:0]  dot_limit;
  logic [15:0]  gap_limit;
  logic         key_prev;
  logic [15:0]  press_len;
  logic [15:0]  gap_len;
  int unsigned  held;
  logic [4:0]   held_bits;
  tick_result_t char_results_q[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Mark string as decimal digits (1 dot, 2 dash, first mark leftmost).
  // Returns {miss, ascii}.
  function automatic logic [7:0] morse_lookup(input int code);
    case (code)
      12:    return "A";
      2111:  return "B";
      2121:  return "C";
      211:   return "D";
      1:     return "E";
      1121:  return "F";
      221:   return "G";
      1111:  return "H";
      11:    return "I";
      1222:  return "J";
      212:   return "K";
      1211:  return "L";
      22:    return "M";
      21:    return "N";
      222:   return "O";
      1221:  return "P";
      2212:  return "Q";
      121:   return "R";
      111:   return "S";
      2:     return "T";
      112:   return "U";
      1112:  return "V";
      122:   return "W";
      2112:  return "X";
      2122:  return "Y";
      2211:  return "Z";
      12222: return "1";
      11222: return "2";
      11122: return "3";
      11112: return "4";
      11111: return "5";
      21111: return "6";
      22111: return "7";
      22211: return "8";
      22221: return "9";
      22222: return "0";
      default: return {1'b1, 7'h20};
    endcase
  endfunction

  function automatic tick_result_t predict_tick(input logic key);
    tick_result_t r;
    logic         decode;
    int           code;
    r      = '0;
    decode = 1'b0;
    if (key) begin
      if (!key_prev) press_len = 16'd1;
      else if (press_len != 16'hFFFF) press_len++;
    end else if (key_prev) begin
      r.mark_valid      = 1'b1;
      r.mark_is_dash    = press_len > dot_limit;
      held_bits[held]   = r.mark_is_dash;
      held++;
      gap_len = '0;
      if (held >= MARKS_PER_CHAR) decode = 1'b1;
    end else begin
      if (gap_len != 16'hFFFF) gap_len++;
      if (held != 0 && gap_len > gap_limit) decode = 1'b1;
    end
    if (decode) begin
      code = 0;
      for (int i = 0; i < held; i++) code = code * 10 + (held_bits[i] ? 2 : 1);
      r.char_valid = 1'b1;
      {r.unmatched, r.char_code} = morse_lookup(code);
      held      = 0;
      held_bits = '0;
    end
    key_prev = key;
    return r;
  endfunction

  task automatic report(input string what, input tick_result_t want, input tick_result_t got);
    errors++;
    if (errors <= 10)
      $display("%0t: %s: expected mv=%0b md=%0b cv=%0b ch=%h um=%0b, got mv=%0b md=%0b cv=%0b ch=%h um=%0b",
               $time, what, want.mark_valid, want.mark_is_dash, want.char_valid,
               want.char_code, want.unmatched, got.mark_valid, got.mark_is_dash,
               got.char_valid, got.char_code, got.unmatched);
  endtask

  always @(posedge clk) begin
    tick_result_t got;
    tick_result_t want;
    if (rst) begin
      dot_limit = DOT_LIMIT_INIT;
      gap_limit = GAP_LIMIT_INIT;
      key_prev  = 1'b0;
      press_len = '0;
      gap_len   = '0;
      held      = 0;
      held_bits = '0;
      char_results_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == mkd_pkg::REG_DOT_MAX) dot_limit = cfg_data;
        else if (cfg_index == mkd_pkg::REG_LETTER_GAP) gap_limit = cfg_data;
      end
      // results first: a result never belongs to the item accepted at the same edge
      if (m_tvalid && m_tready) begin
        got = tick_result_t'(m_tdata[RESULT_W-1:0]);
        if (char_results_q.size() == 0) begin
          report("result with nothing expected", '0, got);
        end else begin
          want = char_results_q.pop_front();
          if (got.mark_valid !== want.mark_valid || got.mark_is_dash !== want.mark_is_dash ||
              got.char_valid !== want.char_valid || got.char_code !== want.char_code ||
              got.unmatched !== want.unmatched)
            report("result mismatch", want, got);
        end
      end
      if (s_tvalid && s_tready) char_results_q.push_back(predict_tick(s_tdata[0]));
    end
    pending <= char_results_q.size();
  end

endmodule

// File: sim/tb.sv
// Top of the Morse key decoder bench: clock, reset, tick stimulus, output backpressure
// and the verdict. Depends on mkd_pkg, morse_key_decoder_core and mkd_checker.
`timescale 1ns / 1ps

module tb;

  localparam int LONG_HOLD   = 400;   // receiver stall long enough to back up the input
  localparam int QUIET_LIMIT = 5000;  // cycles with no item moving before giving up
  localparam int PHASE_TICKS = 240;   // random ticks per configuration phase

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            s_tvalid  = 1'b0;
  wire                             s_tready;
  logic [mkd_pkg::IN_TDATA_W-1:0]  s_tdata   = '0;
  wire                             m_tvalid;
  logic                            m_tready  = 1'b0;
  wire  [mkd_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            cfg_we    = 1'b0;
  logic [0:0]                      cfg_index = mkd_pkg::REG_DOT_MAX;
  logic [mkd_pkg::CFG_W-1:0]       cfg_data  = '0;

  int errors;
  int pending;

  // Stimulus copies of the register values, used only to shape press and gap lengths
  int dot_max    = 250;
  int letter_gap = 1500;

  int ticks_sent = 0;
  bit tx_idle    = 1'b0;
  bit rx_idle    = 1'b0;
  int hold_req   = 0;   // bumped by the stimulus to request one long receiver stall

  always #10 clk = ~clk;

  morse_key_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mkd_checker i_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // Idle length: mostly none, some short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: random stalls, plus one long stall on request
  always @(posedge clk) begin
    int hold_seen;
    int stall_left;
    int g;
    if (rst) begin
      hold_seen  = hold_req;
      stall_left = 0;
      m_tready  <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen  = hold_req;
      stall_left = LONG_HOLD - 1;
      m_tready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (rx_idle) begin
      g = idle_len();
      if (g > 0) begin
        stall_left = g - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: no item moving on either channel for too long
  always @(posedge clk) begin
    int quiet;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // One tick item; an optional gap before it when sender idling is on
  task automatic send_tick(input logic key);
    int g;
    g = tx_idle ? idle_len() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= mkd_pkg::IN_TDATA_W'(key);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic send_run(input logic key, input int n);
    repeat (n) send_tick(key);
  endtask

  // Stop sending and wait until every expected result item has come back.
  // pending is registered, so step the clock before looking at it.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= mkd_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mkd_pkg::REG_DOT_MAX) dot_max = val;
    else letter_gap = val;
  endtask

  // Well-formed letter: 1..5 marks, gaps kept within the letter gap, then a closing gap.
  // With five marks the release tick itself decodes, so the next press may follow at once.
  task automatic send_letter();
    int   n;
    int   len;
    logic dash;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      dash = 1'($urandom_range(0, 1));
      if (dash || dot_max == 0) len = dot_max + $urandom_range(1, 3);
      else len = $urandom_range(1, dot_max);
      send_run(1'b1, len);
      if (i < n - 1) send_run(1'b0, $urandom_range(1, letter_gap + 1));
    end
    if (n == 5 && $urandom_range(0, 1)) send_run(1'b0, 1);
    else send_run(1'b0, letter_gap + 2 + $urandom_range(0, 3));
  endtask

  initial begin
    int  stop_at;
    bit  held_off;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // --- directed, reset dot limit (250), no idling ---
    send_run(1'b0, 3);                        // released ticks, no marks held
    send_run(1'b1, 250);                      // longest dot
    send_run(1'b0, 1);
    send_run(1'b1, 251);                      // shortest dash
    send_run(1'b0, 1);                        // release, marks stay held
    write_reg(mkd_pkg::REG_LETTER_GAP, 2);
    send_run(1'b0, 3);                        // gap reaches the limit, then one past: "A"

    // --- directed, small settings: boundaries on both limits ---
    write_reg(mkd_pkg::REG_DOT_MAX, 3);
    write_reg(mkd_pkg::REG_LETTER_GAP, 5);
    send_run(1'b1, 3);
    send_run(1'b0, 6);                        // gap equals the limit: still one letter
    send_run(1'b1, 4);
    send_run(1'b0, 7);
    // five marks with no match, decoded on the fifth release
    for (int i = 0; i < 5; i++) begin
      send_run(1'b1, (i % 2) ? 4 : 1);
      send_run(1'b0, 1);
    end
    // four dashes: not in the table, decoded by the gap
    for (int i = 0; i < 4; i++) begin
      send_run(1'b1, 5);
      send_run(1'b0, (i == 3) ? 7 : 1);
    end
    // five dashes ("0"), next press right after the release tick
    for (int i = 0; i < 5; i++) begin
      send_run(1'b1, 5);
      send_run(1'b0, 1);
    end
    send_run(1'b1, 2);
    send_run(1'b0, 7);

    // --- both limits at zero: every press is a dash, first gap tick decodes ---
    write_reg(mkd_pkg::REG_DOT_MAX, 0);
    write_reg(mkd_pkg::REG_LETTER_GAP, 0);
    send_run(1'b1, 1);
    send_run(1'b0, 3);

    // --- random phases: letters with random content plus some noise ---
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(mkd_pkg::REG_DOT_MAX, (ph == 0) ? 0 : $urandom_range(1, 6));
      write_reg(mkd_pkg::REG_LETTER_GAP, (ph == 1) ? 0 : $urandom_range(1, 12));
      tx_idle  = (ph != 3);                   // phase 3 runs back to back
      rx_idle  = (ph != 3);
      stop_at  = ticks_sent + PHASE_TICKS;
      held_off = 1'b0;
      while (ticks_sent < stop_at) begin
        if (ph == 2 && !held_off && ticks_sent > stop_at - 150) begin
          hold_req++;                         // receiver stalls, sender keeps offering
          held_off = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 12)) send_tick(1'($urandom_range(0, 1)));
        end else begin
          send_letter();
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
